// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while reset is released.
`define BAM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, including while reset is applied.
`define BAM_ASSERT_RST(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bam_pkg.sv
`default_nettype none

package bam_pkg;

	// Default sizing.
	localparam int MAX_LEVELS_DEF    = 9;
	localparam int POSITION_BITS_DEF = 32;

	// Fixed field widths.
	localparam int VEC_W     = 64;
	localparam int SYM_W     = 8;
	localparam int SCORE_W   = 4;
	localparam int END_W     = 32;
	localparam int LEN_W     = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 6;

	typedef logic [VEC_W-1:0] vec_t;

	// Request codes carried in req_type.
	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_TEXT = 2'd1,
		REQ_EOB  = 2'd2
	} req_e;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRORS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTEND_BETTER  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTEND_SAME    = 2'd3;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [SYM_W-1:0] symbol;
		vec_t             table_mask;
	} in_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] match_score;
		logic [END_W-1:0]   match_end;
	} out_item_t;

	// Control handed to each level cell.
	typedef struct packed {
		logic update;
		logic restart;
	} cell_ctl_t;

	// Arithmetic right shift by one: the sign bit is copied in.
	function automatic vec_t asr1(input vec_t x);
		return {x[VEC_W-1], x[VEC_W-1:1]};
	endfunction

	// Start vector of one error level: ones above the pattern length,
	// arithmetically shifted right by the level.
	function automatic vec_t restart_vec(input logic [LEN_W-1:0] len, input int unsigned level);
		logic signed [VEC_W-1:0] s;
		s = $signed(~{VEC_W{1'b0}} << len);
		return vec_t'(s >>> level);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bitap_approx_match_stream_unit.sv
// Channel | Direction | Handshake             | Payload
// in      | into unit | in_valid / in_stall   | in_data  (req_type, symbol, table_mask)
// out     | from unit | out_valid / out_stall | out_data (match_score, match_end)
// cfg     | into unit | cfg_we                | cfg_index, cfg_data
//
// One beat is taken per cycle while in_stall is low; the result of a taken beat passes
// through the first stage and then the output register before it is offered.
// The rate is set by the symbol table's registered read and the level cell chain,
// which updates every error level in use for one byte together.
// Reset is asynchronous; the symbol table holds no defined value until loaded.
// A result waiting under out_stall stays in the output register; in_stall rises
// only when that register is held and the first stage is also occupied.
`default_nettype none

module bitap_approx_match_stream_unit
	import bam_pkg::*;
#(
	parameter int MAX_LEVELS    = MAX_LEVELS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data
);

	localparam int LVL_W = $clog2(MAX_LEVELS + 1);

	// Configuration registers.
	logic [SCORE_W-1:0] max_err_q;
	logic [LEN_W-1:0]   len_q;
	logic               ext_better_q;
	logic               ext_same_q;

	// Pipeline and run state.
	logic               valid_s1;
	logic [1:0]         req_s1;
	logic [POSITION_BITS-1:0] pos_q;
	logic               run_open_q;
	logic [SCORE_W-1:0] run_score_q;
	logic [END_W-1:0]   run_end_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               accept;
	logic               adv;
	logic               go;
	logic               is_text;
	logic               cfg_restart;
	logic               restart_all;
	logic [LEN_W-1:0]   restart_len;
	logic [LVL_W-1:0]   top_lvl;
	vec_t               bits;
	vec_t               ev_w [MAX_LEVELS];
	vec_t               nv_w [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] active;
	logic               hit;
	logic [SCORE_W-1:0] score;
	logic [END_W-1:0]   pos32;
	logic               ext;
	logic               emit;
	logic [SCORE_W-1:0] res_score;
	logic [END_W-1:0]   res_end;
	logic               run_open_d;
	logic [SCORE_W-1:0] run_score_d;
	logic [END_W-1:0]   run_end_d;

	// Handshake: the output register frees the first stage.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;
	assign go       = valid_s1 && adv;
	assign is_text  = (req_s1 == REQ_TEXT);

	// Configuration writes.
	assign cfg_restart = cfg_we &&
		(cfg_index == CFG_MAX_ERRORS || cfg_index == CFG_PATTERN_LENGTH);
	assign restart_len = (cfg_we && cfg_index == CFG_PATTERN_LENGTH) ? cfg_data[LEN_W-1:0] : len_q;
	assign restart_all = cfg_restart || (go && req_s1 == REQ_EOB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_err_q    <= '0;
			len_q        <= LEN_W'(1);
			ext_better_q <= 1'b0;
			ext_same_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_ERRORS:     max_err_q    <= cfg_data[SCORE_W-1:0];
				CFG_PATTERN_LENGTH: len_q        <= cfg_data[LEN_W-1:0];
				CFG_EXTEND_BETTER:  ext_better_q <= cfg_data[0];
				CFG_EXTEND_SAME:    ext_same_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Highest error level in use.
	always_comb begin
		if (32'(max_err_q) > 32'(MAX_LEVELS - 1)) begin
			top_lvl = LVL_W'(MAX_LEVELS - 1);
		end else begin
			top_lvl = LVL_W'(max_err_q);
		end
	end

	// Symbol mask table, read as the text beat is taken.
	bam_sym_table u_table (
		.clk     (clk),
		.wr_en   (accept && in_data.req_type == REQ_LOAD),
		.wr_addr (in_data.symbol),
		.wr_data (in_data.table_mask),
		.rd_en   (accept && in_data.req_type == REQ_TEXT),
		.rd_addr (in_data.symbol),
		.rd_data (bits)
	);

	// First stage holds the request while the table is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_data.req_type;
		end
	end

	// Chain of level cells; level zero sees all-zero neighbors.
	for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_lvl
		cell_ctl_t ctl;

		assign active[k]   = (32'(top_lvl) >= 32'(k));
		assign ctl.update  = go && is_text && active[k];
		assign ctl.restart = restart_all;

		if (k == 0) begin : g_first
			bam_cell #(.LEVEL(k)) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.bits        (bits),
				.restart_len (restart_len),
				.up_ev       ('0),
				.up_nv       ('0),
				.ev          (ev_w[k]),
				.nv          (nv_w[k])
			);
		end else begin : g_next
			bam_cell #(.LEVEL(k)) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.bits        (bits),
				.restart_len (restart_len),
				.up_ev       (ev_w[k-1]),
				.up_nv       (nv_w[k-1]),
				.ev          (ev_w[k]),
				.nv          (nv_w[k])
			);
		end
	end

	// Lowest active level with bit 0 set gives the score.
	always_comb begin
		hit   = 1'b0;
		score = '0;
		for (int k = MAX_LEVELS - 1; k >= 0; k--) begin
			if (active[k] && nv_w[k][0]) begin
				hit   = 1'b1;
				score = SCORE_W'(k);
			end
		end
	end

	assign pos32 = END_W'(pos_q);
	assign ext   = ext_better_q || ext_same_q;

	// Hit reporting and run merging.
	always_comb begin
		run_open_d  = run_open_q;
		run_score_d = run_score_q;
		run_end_d   = run_end_q;
		emit        = 1'b0;
		res_score   = run_score_q;
		res_end     = run_end_q;
		if (go && is_text) begin
			if (hit) begin
				if (run_open_q) begin
					if (ext && score < run_score_q) begin
						run_score_d = score;
						run_end_d   = pos32;
					end else if (ext && score == run_score_q) begin
						if (ext_same_q) begin
							run_end_d = pos32;
						end
					end else begin
						run_open_d = 1'b0;
						emit       = 1'b1;
					end
				end else if (ext) begin
					run_open_d  = 1'b1;
					run_score_d = score;
					run_end_d   = pos32;
				end else begin
					emit      = 1'b1;
					res_score = score;
					res_end   = pos32;
				end
			end else if (run_open_q) begin
				run_open_d = 1'b0;
				emit       = 1'b1;
			end
		end else if (go && req_s1 == REQ_EOB) begin
			emit        = run_open_q;
			run_open_d  = 1'b0;
			run_score_d = '0;
			run_end_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			run_open_q  <= 1'b0;
			run_score_q <= '0;
			run_end_q   <= '0;
		end else if (cfg_restart) begin
			pos_q       <= '0;
			run_open_q  <= 1'b0;
			run_score_q <= '0;
			run_end_q   <= '0;
		end else begin
			run_open_q  <= run_open_d;
			run_score_q <= run_score_d;
			run_end_q   <= run_end_d;
			if (go && req_s1 == REQ_EOB) begin
				pos_q <= '0;
			end else if (go && is_text) begin
				pos_q <= pos_q + POSITION_BITS'(1);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit && adv) begin
			out_q.match_score <= res_score;
			out_q.match_end   <= res_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/bam_sym_table.sv
`default_nettype none

module bam_sym_table
	import bam_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [SYM_W-1:0] wr_addr,
	input  wire vec_t             wr_data,
	input  wire logic             rd_en,
	input  wire logic [SYM_W-1:0] rd_addr,
	output vec_t                  rd_data
);

	vec_t mem_q [2**SYM_W];
	vec_t rd_data_q;

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/bam_cell.sv
`default_nettype none

module bam_cell
	import bam_pkg::*;
#(
	parameter int unsigned LEVEL = 0
)
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctl_t        ctl,
	input  wire vec_t             bits,
	input  wire logic [LEN_W-1:0] restart_len,
	input  wire vec_t             up_ev,
	input  wire vec_t             up_nv,
	output vec_t                  ev,
	output vec_t                  nv
);

	vec_t ev_q;

	// Match, substitution, insertion and deletion terms of this level.
	assign nv = (asr1(ev_q) & bits) | asr1(up_ev) | asr1(up_nv) | up_ev;
	assign ev = ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q <= restart_vec(LEN_W'(1), LEVEL);
		end else if (ctl.restart) begin
			ev_q <= restart_vec(restart_len, LEVEL);
		end else if (ctl.update) begin
			ev_q <= nv;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/bam_checker.sv
`default_nettype none
`include "assert_macros.svh"

module bam_checker
	import bam_pkg::*;
#(
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
)
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_data
);

	// A held result beat keeps its value.
	`BAM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result beat changed while stalled")

	// The input side only waits behind a held result beat.
	`BAM_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a held result")

	// Scores never exceed the top error level.
	`BAM_ASSERT(a_score_range, out_valid |-> 32'(out_data.match_score) <= 32'(MAX_LEVELS - 1), "score beyond top error level")

	// Nothing is offered or refused while reset is applied.
	`BAM_ASSERT_RST(a_reset_quiet, !arst_n |-> !out_valid && !in_stall, "handshake active during reset")

endmodule

bind bitap_approx_match_stream_unit bam_checker #(.MAX_LEVELS(MAX_LEVELS)) u_bam_checker (.*);

`default_nettype wire

// File: bench/bitap_approx_match_stream_unit_test.sv
`timescale 1ns / 100ps

module bitap_approx_match_stream_unit_test;
	import bam_pkg::*;

	localparam int LEVELS = MAX_LEVELS_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 800;
	// The package names no code for the fourth request value, which the block ignores.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Tracks the matcher state and holds the matches that are still due.
	class bitap_scoreboard;
		vec_t        level_vec[LEVELS];
		vec_t        sym_mask[256];
		logic [3:0]  max_err;
		logic [5:0]  pat_len;
		bit          ext_better;
		bit          ext_same;
		logic [31:0] position;
		bit          run_open;
		logic [3:0]  run_score;
		logic [31:0] run_end;
		out_item_t   pending_hits[$];
		int unsigned failures;

		function new();
			max_err = 0;
			pat_len = 1;
			ext_better = 0;
			ext_same = 0;
			failures = 0;
			for (int i = 0; i < 256; i++) sym_mask[i] = '0;
			restart();
		endfunction

		// Reload the level vectors from the start mask and reopen the buffer.
		function void restart();
			vec_t start;
			start = {64{1'b1}} << pat_len;
			for (int k = 0; k < LEVELS; k++) level_vec[k] = $signed(start) >>> k;
			position = '0;
			run_open = 0;
			run_score = '0;
			run_end = '0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_MAX_ERRORS: begin
					max_err = val[3:0];
					restart();
				end
				CFG_PATTERN_LENGTH: begin
					pat_len = val[5:0];
					restart();
				end
				CFG_EXTEND_BETTER: ext_better = val[0];
				CFG_EXTEND_SAME: ext_same = val[0];
				default: ;
			endcase
		endfunction

		function void push_hit(logic [3:0] score, logic [31:0] end_pos);
			out_item_t hit;
			hit.match_score = score;
			hit.match_end = end_pos;
			pending_hits.push_back(hit);
		endfunction

		// Advance every error level in use by one text byte and decide what gets reported.
		function void scan_byte(logic [7:0] sym);
			vec_t        bits;
			vec_t        nv[LEVELS];
			int          top;
			int          score;
			bit          ext;
			logic [31:0] here;
			bits = sym_mask[sym];
			top = (max_err > LEVELS - 1) ? LEVELS - 1 : max_err;
			for (int k = 0; k < LEVELS; k++) nv[k] = level_vec[k];
			nv[0] = vec_t'($signed(level_vec[0]) >>> 1) & bits;
			for (int k = 1; k <= top; k++)
				nv[k] = (vec_t'($signed(level_vec[k]) >>> 1) & bits)
					| vec_t'($signed(level_vec[k-1]) >>> 1)
					| vec_t'($signed(nv[k-1]) >>> 1)
					| level_vec[k-1];
			for (int k = 0; k <= top; k++) level_vec[k] = nv[k];
			score = -1;
			for (int k = 0; k <= top; k++)
				if (score < 0 && nv[k][0]) score = k;
			here = position;
			position = position + 1;
			ext = ext_better | ext_same;

			if (score >= 0) begin
				if (run_open) begin
					if (ext && score < run_score) begin
						run_score = 4'(score);
						run_end = here;
					end else if (ext && score == run_score) begin
						if (ext_same) run_end = here;
					end else begin
						// A worse hit, or any hit with merging off, closes the run.
						run_open = 0;
						push_hit(run_score, run_end);
					end
				end else if (ext) begin
					run_open = 1;
					run_score = 4'(score);
					run_end = here;
				end else begin
					push_hit(4'(score), here);
				end
			end else if (run_open) begin
				run_open = 0;
				push_hit(run_score, run_end);
			end
		endfunction

		function void note_beat(in_item_t it);
			case (it.req_type)
				REQ_LOAD: sym_mask[it.symbol] = it.table_mask;
				REQ_TEXT: scan_byte(it.symbol);
				REQ_EOB: begin
					if (run_open) push_hit(run_score, run_end);
					restart();
				end
				default: ;
			endcase
		endfunction

		function void check_beat(out_item_t got);
			out_item_t want;
			if (pending_hits.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("ERROR: unexpected match score %0d end %0d",
						got.match_score, got.match_end);
				return;
			end
			want = pending_hits.pop_front();
			if (got.match_score !== want.match_score || got.match_end !== want.match_end) begin
				failures++;
				if (failures <= 10)
					$display("ERROR: match expected score %0d end %0d, got score %0d end %0d",
						want.match_score, want.match_end, got.match_score, got.match_end);
			end
		endfunction

		function int unsigned outstanding();
			return pending_hits.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;

	bitap_scoreboard tracker;
	bit              loaded[256];
	logic [7:0]      pat_sym[64];
	int unsigned     gap_max;
	int unsigned     stall_max;
	int unsigned     stall_left;
	int unsigned     cycle_count;

	bitap_approx_match_stream_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: check each taken beat, then hold off for a drawn number of cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				tracker.check_beat(out_data);
				stall_left = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
			end else if (out_stall && stall_left > 0) begin
				stall_left--;
			end
		end
	end

	always @(negedge clk) out_stall <= (stall_left != 0);

	function automatic in_item_t make_item(input logic [1:0] req, input logic [7:0] sym,
		input vec_t mask);
		in_item_t it;
		it.req_type = req;
		it.symbol = sym;
		it.table_mask = mask;
		return it;
	endfunction

	function automatic vec_t random_word();
		return {$urandom, $urandom};
	endfunction

	// Mask word for one symbol: ones above the length, one bit per matching position.
	function automatic vec_t pattern_mask(input logic [7:0] sym, input int unsigned len);
		vec_t m;
		m = {64{1'b1}} << len;
		for (int i = 0; i < len; i++)
			if (pat_sym[i] == sym) m[len-1-i] = 1'b1;
		return m;
	endfunction

	// Offer one beat after a drawn gap and hold it until the block takes it.
	task automatic send_item(input in_item_t it);
		int unsigned gap;
		gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		if (it.req_type == REQ_LOAD) loaded[it.symbol] = 1'b1;
		tracker.note_beat(it);
	endtask

	task automatic send_text(input logic [7:0] sym);
		send_item(make_item(REQ_TEXT, sym, random_word()));
	endtask

	// Stop sending and wait until every match is in and the pipeline is empty.
	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk) cfg_we <= 1'b0;
		tracker.set_register(idx, val);
	endtask

	task automatic write_all(input int unsigned errs, input int unsigned len,
		input bit better, input bit same);
		write_register(CFG_MAX_ERRORS, CFG_W'(errs));
		write_register(CFG_PATTERN_LENGTH, CFG_W'(len));
		write_register(CFG_EXTEND_BETTER, CFG_W'(better));
		write_register(CFG_EXTEND_SAME, CFG_W'(same));
	endtask

	// One setting of the registers, a pattern over a small alphabet, then mostly
	// pattern-like text with mutations, loads, buffer ends and ignored requests mixed in.
	task automatic random_phase(input int unsigned n_items, output int unsigned sent);
		logic [7:0]  alpha[4];
		int unsigned n_alpha;
		int unsigned len;
		int unsigned errs;
		int unsigned cursor;
		int unsigned pick;
		vec_t        m;
		logic [7:0]  s;
		drain();
		gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
		stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
		case ($urandom_range(0, 5))
			0: errs = 0;
			1: errs = 8;
			2: errs = $urandom_range(9, 15);
			default: errs = $urandom_range(0, 3);
		endcase
		case ($urandom_range(0, 7))
			0: len = 0;
			1: len = 63;
			2: len = $urandom_range(10, 62);
			default: len = $urandom_range(1, 8);
		endcase
		write_all(errs, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

		n_alpha = $urandom_range(2, 4);
		for (int i = 0; i < n_alpha; i++) alpha[i] = 8'($urandom_range(0, 255));
		for (int i = 0; i < len; i++) pat_sym[i] = alpha[$urandom_range(0, n_alpha - 1)];
		for (int i = 0; i < n_alpha; i++) begin
			m = pattern_mask(alpha[i], len);
			if ($urandom_range(0, 5) == 0) m ^= random_word();
			send_item(make_item(REQ_LOAD, alpha[i], m));
		end
		sent = n_alpha;

		cursor = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				send_item(make_item(REQ_EOB, 8'($urandom_range(0, 255)), random_word()));
				cursor = 0;
				sent++;
			end else if (pick < 7) begin
				send_item(make_item(REQ_UNUSED, 8'($urandom_range(0, 255)), random_word()));
			end else if (pick < 10) begin
				send_item(make_item(REQ_LOAD, 8'($urandom_range(0, 255)), random_word()));
				sent++;
			end else if (pick < 13) begin
				do s = 8'($urandom_range(0, 255)); while (!loaded[s]);
				send_text(s);
				sent++;
			end else if (pick < 14) begin
				drain();
			end else begin
				if (len > 0 && $urandom_range(0, 9) < 7) begin
					s = pat_sym[cursor];
					cursor = (cursor + 1) % len;
				end else begin
					s = alpha[$urandom_range(0, n_alpha - 1)];
				end
				send_text(s);
				sent++;
			end
		end
	endtask

	initial begin
		int unsigned total;
		int unsigned sent;
		tracker = new();
		arst_n = 1'b1;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		stall_left = 0;
		cycle_count = 0;
		gap_max = 0;
		stall_max = 0;
		for (int i = 0; i < 256; i++) loaded[i] = 1'b0;
		// A clean falling edge on reset, well before the first rising clock edge.
		#1 arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Saturated error count, extreme symbols, an all-zero and an all-one mask,
		// an ignored request and a buffer end.
		write_all(15, 3, 0, 0);
		pat_sym[0] = 8'h00;
		pat_sym[1] = 8'hFF;
		pat_sym[2] = 8'h00;
		send_item(make_item(REQ_LOAD, 8'h00, pattern_mask(8'h00, 3)));
		send_item(make_item(REQ_LOAD, 8'hFF, pattern_mask(8'hFF, 3)));
		send_item(make_item(REQ_LOAD, 8'h55, '0));
		send_item(make_item(REQ_LOAD, 8'hAA, '1));
		send_text(8'h00);
		send_text(8'hFF);
		send_text(8'h00);
		send_text(8'h55);
		send_text(8'hAA);
		send_text(8'h00);
		send_item(make_item(REQ_UNUSED, 8'hFF, '1));
		send_item(make_item(REQ_EOB, 8'h00, '0));

		// Pattern length zero with better-score merging: a run of hits closed by a miss.
		drain();
		write_all(0, 0, 1, 0);
		send_text(8'hAA);
		send_text(8'hAA);
		send_text(8'h55);
		send_text(8'hAA);
		send_item(make_item(REQ_EOB, 8'hAA, '1));

		// Equal-score merging with a few error levels; the run is dropped by the next write.
		drain();
		stall_max = 6;
		gap_max = 6;
		write_all(2, 3, 0, 1);
		send_text(8'h00);
		send_text(8'hFF);
		send_text(8'h00);
		send_text(8'hFF);
		send_text(8'h00);
		send_text(8'h55);
		send_text(8'hAA);

		total = 0;
		while (total < RANDOM_ITEMS) begin
			random_phase($urandom_range(30, 90), sent);
			total += sent;
		end

		drain();
		repeat (8) @(posedge clk);
		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
